// File: rtl/sha1bc_pkg.sv
// Shared types, constants and helper functions for the SHA-1 compression block.
`default_nettype none

package sha1bc_pkg;

    localparam int HASH_WORDS  = 5;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 80;

    typedef logic [31:0] word_t;
    typedef logic [HASH_WORDS-1:0][31:0] hash_t;

    // Standard initial chaining value
    localparam hash_t IV = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                            32'hEFCDAB89, 32'h67452301};

    // Round constants, one per group of twenty rounds
    localparam word_t K0 = 32'h5A827999;
    localparam word_t K1 = 32'h6ED9EBA1;
    localparam word_t K2 = 32'h8F1BBCDC;
    localparam word_t K3 = 32'hCA62C1D6;

    localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
    localparam logic [3:0] LAST_WORD  = 4'(BLOCK_WORDS - 1);
    localparam logic [2:0] LAST_INDEX = 3'(HASH_WORDS - 1);

    // Control from the sequencer to the round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic [6:0] round;
    } round_ctrl_t;

    function automatic word_t rotl1(input word_t x);
        return {x[30:0], x[31]};
    endfunction

    function automatic word_t rotl5(input word_t x);
        return {x[26:0], x[31:27]};
    endfunction

    function automatic word_t rotl30(input word_t x);
        return {x[1:0], x[31:2]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/sha1bc_in_if.sv
// Message word channel: valid, ready and the input item fields.
`default_nettype none

interface sha1bc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic        start_message;
    logic        final_block;

    modport source (output valid, msg_word, start_message, final_block, input ready);
    modport sink (input valid, msg_word, start_message, final_block, output ready);
    modport monitor (input valid, ready, msg_word, start_message, final_block);
endinterface

`default_nettype wire

// File: rtl/sha1bc_out_if.sv
// Digest word channel: valid, ready and the result item fields.
`default_nettype none

interface sha1bc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
    modport monitor (input valid, ready, digest_word, word_index, last_word);
endinterface

`default_nettype wire

// File: rtl/sha1bc_sched_cell.sv
// One cell of the message schedule chain: holds one word, takes its neighbor's on shift.
`default_nettype none

module sha1bc_sched_cell
    import sha1bc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  shift,
    input  wire word_t d,
    output word_t      q
);

    word_t word_reg;

    // Take the neighbor's word on each shift
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= d;
        end
    end

    assign q = word_reg;

endmodule

`default_nettype wire

// File: rtl/sha1bc_round_unit.sv
// SHA-1 working registers a..e and the round datapath, one round per cycle.
`default_nettype none

module sha1bc_round_unit
    import sha1bc_pkg::*;
(
    input  wire logic        clk,
    input  wire round_ctrl_t ctrl,
    input  wire hash_t       chain,
    input  wire word_t       w,
    output hash_t            work
);

    word_t a_reg, b_reg, c_reg, d_reg, e_reg;
    word_t f, k, tmp;

    // Select round function and constant by round group
    always_comb
    begin
        case (ctrl.round) inside
            [7'd0:7'd19]:
            begin
                f = (b_reg & c_reg) | (~b_reg & d_reg);
                k = K0;
            end
            [7'd20:7'd39]:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                k = K1;
            end
            [7'd40:7'd59]:
            begin
                f = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k = K2;
            end
            default:
            begin
                f = b_reg ^ c_reg ^ d_reg;
                k = K3;
            end
        endcase
    end

    assign tmp = rotl5(a_reg) + f + e_reg + k + w;

    // Load from the chaining value, then advance one round per step
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            a_reg <= chain[0];
            b_reg <= chain[1];
            c_reg <= chain[2];
            d_reg <= chain[3];
            e_reg <= chain[4];
        end
        else if (ctrl.step)
        begin
            a_reg <= tmp;
            b_reg <= a_reg;
            c_reg <= rotl30(b_reg);
            d_reg <= c_reg;
            e_reg <= d_reg;
        end
    end

    assign work = {e_reg, d_reg, c_reg, b_reg, a_reg};

endmodule

`default_nettype wire

// File: rtl/sha1_block_compression_unit.sv
// Top level of the SHA-1 block compression unit.
// Usage:
//   msg_in carries one 32-bit big-endian message word per transaction, sixteen
//   to a 512-bit block. start_message on the first word of a block reloads the
//   chaining value from the init registers; final_block on the sixteenth word
//   requests the digest. Padding and length encoding are the caller's job.
//   The config port writes init_a..init_e (index 0..4) at any edge with
//   cfg_we high; other indexes are dropped. New values apply at the next start.
//   Words are taken one per cycle while collecting a block. After the
//   sixteenth word, msg_in.ready stays low while the 80 rounds run through
//   the round unit at one round per cycle and then through the chaining add.
//   For a final block the five digest words H0..H4 appear on digest_out from
//   the cycle after the add, one per accepted transaction, last_word on H4.
//   The digest sits in its own output buffer, so the next message can be fed
//   while the receiver stalls; only the add of a further final block waits
//   until the buffer has drained.
//   Reset restores the standard initial value in the init registers and the
//   chaining value and empties the output buffer.
`default_nettype none

module sha1_block_compression_unit
    import sha1bc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    sha1bc_in_if.sink        msg_in,
    sha1bc_out_if.source     digest_out,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_COLLECT,
        ST_ROUNDS,
        ST_ADD
    } state_t;

    state_t      state_reg;
    logic [3:0]  word_cnt_reg;
    logic [6:0]  round_cnt_reg;
    logic        final_reg;

    word_t       init_reg [HASH_WORDS];
    hash_t       chain_reg;
    hash_t       sums;
    hash_t       work;

    word_t       obuf_reg [HASH_WORDS];
    logic        obuf_busy_reg;
    logic [2:0]  oidx_reg;

    word_t       cell_q [BLOCK_WORDS];
    word_t       feedback;
    logic        shift;
    logic        in_fire;
    logic        out_fire;
    logic        add_go;
    round_ctrl_t rctrl;

    assign in_fire  = msg_in.valid && msg_in.ready;
    assign out_fire = digest_out.valid && digest_out.ready;
    assign msg_in.ready = (state_reg == ST_COLLECT);
    assign add_go = (state_reg == ST_ADD) && !(final_reg && obuf_busy_reg);

    // Sequencer: collect sixteen words, run the rounds, then add
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COLLECT;
            word_cnt_reg  <= '0;
            round_cnt_reg <= '0;
            final_reg     <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_COLLECT:
                begin
                    if (in_fire)
                    begin
                        if (word_cnt_reg == LAST_WORD)
                        begin
                            word_cnt_reg  <= '0;
                            round_cnt_reg <= '0;
                            final_reg     <= msg_in.final_block;
                            state_reg     <= ST_ROUNDS;
                        end
                        else
                        begin
                            word_cnt_reg <= word_cnt_reg + 4'd1;
                        end
                    end
                end
                ST_ROUNDS:
                begin
                    if (round_cnt_reg == LAST_ROUND)
                    begin
                        round_cnt_reg <= '0;
                        state_reg     <= ST_ADD;
                    end
                    else
                    begin
                        round_cnt_reg <= round_cnt_reg + 7'd1;
                    end
                end
                ST_ADD:
                begin
                    if (add_go)
                    begin
                        state_reg <= ST_COLLECT;
                    end
                end
                default:
                begin
                    state_reg <= ST_COLLECT;
                end
            endcase
        end
    end

    // Write the init registers; drop out-of-range indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                init_reg[i] <= IV[i];
            end
        end
        else if (cfg_we && (cfg_index < 3'(HASH_WORDS)))
        begin
            init_reg[cfg_index] <= cfg_data;
        end
    end

    // Chaining value: reload on start, accumulate after the rounds
    always_comb
    begin
        for (int i = 0; i < HASH_WORDS; i++)
        begin
            sums[i] = chain_reg[i] + work[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IV;
        end
        else if (in_fire && (word_cnt_reg == '0) && msg_in.start_message)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                chain_reg[i] <= init_reg[i];
            end
        end
        else if (add_go)
        begin
            chain_reg <= sums;
        end
    end

    // Schedule chain: cell 0 takes the new word, or the expanded word during rounds
    assign shift    = in_fire || (state_reg == ST_ROUNDS);
    assign feedback = rotl1(cell_q[2] ^ cell_q[7] ^ cell_q[13] ^ cell_q[15]);

    for (genvar j = 0; j < BLOCK_WORDS; j++)
    begin : g_cell
        if (j == 0)
        begin : g_head
            sha1bc_sched_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     ((state_reg == ST_ROUNDS) ? feedback : msg_in.msg_word),
                .q     (cell_q[j])
            );
        end
        else
        begin : g_body
            sha1bc_sched_cell u_cell (
                .clk   (clk),
                .shift (shift),
                .d     (cell_q[j-1]),
                .q     (cell_q[j])
            );
        end
    end

    // Round unit: load a..e on the last word, step during the rounds
    assign rctrl.load  = in_fire && (word_cnt_reg == LAST_WORD);
    assign rctrl.step  = (state_reg == ST_ROUNDS);
    assign rctrl.round = round_cnt_reg;

    sha1bc_round_unit u_round (
        .clk   (clk),
        .ctrl  (rctrl),
        .chain (chain_reg),
        .w     (cell_q[BLOCK_WORDS-1]),
        .work  (work)
    );

    // Output buffer: capture the digest, shift out one word per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obuf_busy_reg <= 1'b0;
            oidx_reg      <= '0;
        end
        else if (add_go && final_reg)
        begin
            obuf_busy_reg <= 1'b1;
            oidx_reg      <= '0;
        end
        else if (out_fire)
        begin
            oidx_reg <= oidx_reg + 3'd1;
            if (oidx_reg == LAST_INDEX)
            begin
                obuf_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (add_go && final_reg)
        begin
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                obuf_reg[i] <= sums[i];
            end
        end
        else if (out_fire)
        begin
            for (int i = 0; i < HASH_WORDS - 1; i++)
            begin
                obuf_reg[i] <= obuf_reg[i+1];
            end
        end
    end

    assign digest_out.valid       = obuf_busy_reg;
    assign digest_out.digest_word = obuf_reg[0];
    assign digest_out.word_index  = oidx_reg;
    assign digest_out.last_word   = (oidx_reg == LAST_INDEX);

endmodule

`default_nettype wire

// File: rtl/sha1bc_checker.sv
// Port-level checks for the SHA-1 compression unit, bound to the top level.
`default_nettype none

module sha1bc_checker
    import sha1bc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        digest_valid,
    input  wire logic        digest_ready,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_index,
    input  wire logic        last_word
);

    // Hold a stalled digest transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_ready) |=> digest_valid)
        else $error("digest valid dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_ready) |=> $stable(digest_word))
        else $error("digest word changed while stalled");

    // Flag the last word exactly on H4
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (last_word == (word_index == LAST_INDEX)))
        else $error("last_word does not match word_index");

    // Advance through the digest words without gaps
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && digest_ready && !last_word) |=>
        (digest_valid && (word_index == $past(word_index) + 3'd1)))
        else $error("digest words not sent in sequence");

endmodule

bind sha1_block_compression_unit sha1bc_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .digest_valid (digest_out.valid),
    .digest_ready (digest_out.ready),
    .digest_word  (digest_out.digest_word),
    .word_index   (digest_out.word_index),
    .last_word    (digest_out.last_word)
);

`default_nettype wire
